[rtl/xcfp_pkg.sv]
// Package with the shared types and constants of the XOR-checked frame parser.
`default_nettype none

package xcfp_pkg;

    // Header and token bytes of a frame
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int unsigned BYTE_W = 8;

    // Parse phase; the spare code falls to the hunting arm
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_N     = 3'd1,
        PH_E     = 3'd2,
        PH_R     = 3'd3,
        PH_LEN   = 3'd4,
        PH_COLON = 3'd5,
        PH_BODY  = 3'd6
    } t_phase;

    // Kind of result word
    typedef enum logic [1:0] {
        KIND_BODY = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // One result from the parser to the output stage
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              cmd;
    } t_result;

endpackage

`default_nettype wire

[rtl/xor_checked_frame_parser.sv]
// Top level of the XOR-checked frame parser: input register, parser and output register.
// A result word passes through the input register and then the output register before it is
// valid on the master side.
// Throughput: one input word per cycle when not stalled; the parser state updates as each word moves on.
// Output backpressure stalls the input register, and then the slave side.
// Reset (synchronous, active low) empties both registers and returns the parser to hunting.
`default_nettype none

module xor_checked_frame_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // [7:0] out_byte
    output logic [2:0]        m_axis_tuser   // [1:0] out_kind, [2] is_command
);

    logic                          r_in_valid;
    logic [xcfp_pkg::BYTE_W-1:0]   r_in_byte;
    logic                          w_out_free;
    logic                          w_step;
    xcfp_pkg::t_result             w_res;
    xcfp_pkg::t_kind               w_kind;
    logic                          w_cmd;

    // A word moves on when the output register can take its result
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    xcfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    xcfp_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_kind  (w_kind),
        .o_cmd   (w_cmd)
    );

    assign m_axis_tuser = {w_cmd, w_kind};

endmodule

`default_nettype wire

[rtl/xcfp_parser.sv]
// Frame parser state machine: phase, length count, running XOR and command flag.
`default_nettype none

module xcfp_parser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [xcfp_pkg::BYTE_W-1:0] i_byte,
    output xcfp_pkg::t_result              o_res
);

    xcfp_pkg::t_phase              r_phase, n_phase;
    logic [xcfp_pkg::BYTE_W-1:0]   r_bytes_left, n_bytes_left;
    logic [xcfp_pkg::BYTE_W-1:0]   r_xor, n_xor;
    logic                          r_cmd_seen, n_cmd_seen;
    logic                          w_more_body;

    assign w_more_body = (r_bytes_left > 8'd1);

    // Next state of the parser for the current word
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_xor        = r_xor;
        n_cmd_seen   = r_cmd_seen;
        case (r_phase)
            xcfp_pkg::PH_N: begin
                if (i_byte == xcfp_pkg::CH_N) begin
                    n_xor   = r_xor ^ i_byte;
                    n_phase = xcfp_pkg::PH_E;
                end else if (i_byte == xcfp_pkg::CH_U) begin
                    n_phase      = xcfp_pkg::PH_N;
                    n_bytes_left = '0;
                    n_xor        = xcfp_pkg::CH_U;
                    n_cmd_seen   = 1'b0;
                end else begin
                    n_phase      = xcfp_pkg::PH_HUNT;
                    n_bytes_left = '0;
                    n_xor        = '0;
                    n_cmd_seen   = 1'b0;
                end
            end
            xcfp_pkg::PH_E: begin
                if (i_byte == xcfp_pkg::CH_E) begin
                    n_xor   = r_xor ^ i_byte;
                    n_phase = xcfp_pkg::PH_R;
                end else begin
                    n_phase      = xcfp_pkg::PH_HUNT;
                    n_bytes_left = '0;
                    n_xor        = '0;
                    n_cmd_seen   = 1'b0;
                end
            end
            xcfp_pkg::PH_R: begin
                if (i_byte == xcfp_pkg::CH_R) begin
                    n_xor   = r_xor ^ i_byte;
                    n_phase = xcfp_pkg::PH_LEN;
                end else begin
                    n_phase      = xcfp_pkg::PH_HUNT;
                    n_bytes_left = '0;
                    n_xor        = '0;
                    n_cmd_seen   = 1'b0;
                end
            end
            xcfp_pkg::PH_LEN: begin
                n_bytes_left = i_byte;
                n_xor        = r_xor ^ i_byte;
                n_cmd_seen   = 1'b0;
                n_phase      = xcfp_pkg::PH_COLON;
            end
            xcfp_pkg::PH_COLON: begin
                if (i_byte == xcfp_pkg::CH_COLON) begin
                    n_xor   = r_xor ^ i_byte;
                    n_phase = xcfp_pkg::PH_BODY;
                end else begin
                    n_phase      = xcfp_pkg::PH_HUNT;
                    n_bytes_left = '0;
                    n_xor        = '0;
                    n_cmd_seen   = 1'b0;
                end
            end
            xcfp_pkg::PH_BODY: begin
                if (w_more_body) begin
                    n_xor        = r_xor ^ i_byte;
                    n_cmd_seen   = 1'b1;
                    n_bytes_left = r_bytes_left - 8'd1;
                end else begin
                    // Checksum word closes the frame
                    n_phase      = xcfp_pkg::PH_HUNT;
                    n_bytes_left = '0;
                    n_xor        = '0;
                    n_cmd_seen   = 1'b0;
                end
            end
            default: begin
                if (i_byte == xcfp_pkg::CH_U) begin
                    n_phase      = xcfp_pkg::PH_N;
                    n_bytes_left = '0;
                    n_xor        = xcfp_pkg::CH_U;
                    n_cmd_seen   = 1'b0;
                end else begin
                    n_phase = xcfp_pkg::PH_HUNT;
                end
            end
        endcase
    end

    // Result for the current word
    always_comb begin
        o_res       = '0;
        o_res.kind  = xcfp_pkg::KIND_BODY;
        case (r_phase)
            xcfp_pkg::PH_BODY: begin
                if (w_more_body) begin
                    o_res.valid = i_step;
                    o_res.kind  = xcfp_pkg::KIND_BODY;
                    o_res.data  = i_byte;
                    o_res.cmd   = !r_cmd_seen;
                end else if (r_xor == i_byte) begin
                    // An empty body with a good checksum gives nothing
                    o_res.valid = i_step && r_cmd_seen;
                    o_res.kind  = xcfp_pkg::KIND_GOOD;
                end else begin
                    o_res.valid = i_step;
                    o_res.kind  = xcfp_pkg::KIND_ERR;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= xcfp_pkg::PH_HUNT;
            r_bytes_left <= '0;
            r_xor        <= '0;
            r_cmd_seen   <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_xor        <= n_xor;
            r_cmd_seen   <= n_cmd_seen;
        end
    end

endmodule

`default_nettype wire

[rtl/xcfp_out_stage.sv]
// Output register of the parser, holding one result word until it is taken.
`default_nettype none

module xcfp_out_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire xcfp_pkg::t_result           i_res,
    output logic                             o_free,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [xcfp_pkg::BYTE_W-1:0]      o_data,
    output xcfp_pkg::t_kind                  o_kind,
    output logic                             o_cmd
);

    logic                          r_valid;
    xcfp_pkg::t_kind               r_kind;
    logic [xcfp_pkg::BYTE_W-1:0]   r_data;
    logic                          r_cmd;

    // The register can take a new word when empty or being emptied now
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;
    assign o_cmd   = r_cmd;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_kind <= i_res.kind;
            r_data <= i_res.data;
            r_cmd  <= i_res.cmd;
        end
    end

endmodule

`default_nettype wire
